// File: hdl/hsv2rgb_pkg.sv
// Shared constants for the HSV to RGB pixel converter.
// Holds field widths, parameter defaults and the hue sector codes.
// Depends on nothing; used by hsv_to_rgb_convert.
package hsv2rgb_pkg;

  localparam int HUE_W = 15;
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int CHANNEL_BITS_DEF = 8;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RED     = 3'd0;
  localparam sector_t SEC_YELLOW  = 3'd1;
  localparam sector_t SEC_GREEN   = 3'd2;
  localparam sector_t SEC_CYAN    = 3'd3;
  localparam sector_t SEC_BLUE    = 3'd4;
  localparam sector_t SEC_MAGENTA = 3'd5;

endpackage

// File: hdl/hsv_to_rgb_convert.sv
// HSV to RGB pixel converter: accepts one pixel per clock on the in_ stream while the output
// is not stalled and delivers one word per pixel on the out_ stream. The eight register
// stages are sector search, saturation products, complements, value products, two stages
// of division by the channel full scale, a reciprocal multiply for the division by fifteen,
// and the output register. Each stage holds its word until the next one frees, so a stall
// on the output fills the bubbles first and never drops a word.
// A hue of 360 degrees or more sets out_tuser and zeroes all three channels.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_convert #(
  parameter int HUE_FRAC_BITS = hsv2rgb_pkg::HUE_FRAC_BITS_DEF,
  parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEF,
  localparam int IN_W = ((hsv2rgb_pkg::HUE_W + 2 * CHANNEL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // hue, saturation, brightness
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // red, green, blue
  output logic             out_tuser   // hue_out_of_range
);
  import hsv2rgb_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int SPAN = 60 * (2 ** HUE_FRAC_BITS);
  localparam int SW = $clog2(SPAN + 1);
  localparam int TW = $clog2(6 * SPAN + 1);
  localparam int CW = (TW > HUE_W) ? TW : HUE_W;
  localparam int XW = CB + SW;
  localparam int PW = CB + XW;
  localparam int ZW = 2 * CB + 4;
  localparam int EW = ZW + 1 - CB;
  localparam int RMW = ZW + 1;
  localparam int WW = CB + 4;
  localparam int K15 = 4 * ((CB + 11) / 4);
  localparam int RW = K15 - 3;
  localparam int QW = WW + RW;
  localparam int NS = 8;
  localparam longint CHAN_MAX = (longint'(1) << CB) - 1;
  localparam longint MD = CHAN_MAX * longint'(SPAN);
  localparam longint RECIP = ((longint'(1) << K15) + 14) / 15;
  localparam logic [CB-1:0] M_C = CB'(CHAN_MAX);
  localparam logic [SW-1:0] SPAN_C = SW'(SPAN);
  localparam logic [XW-1:0] MD_C = XW'(MD);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam logic [RMW-1:0] M1_C = RMW'(CHAN_MAX);
  localparam logic [RMW-1:0] M2_C = RMW'(2 * CHAN_MAX);

  logic [NS:0]   adv;
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;

  always_comb begin
    adv[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NS; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = adv[0];
  assign out_tvalid = vld_r[NS-1];

  // Sector search.
  logic [CW-1:0] hue_ext;
  logic [CB-1:0] sat_in;
  logic [CB-1:0] bri_in;
  sector_t       s1_sec_nxt;
  logic [SW-1:0] s1_rem_nxt;
  logic          s1_oor_nxt;

  assign hue_ext = CW'(in_tdata[HUE_W-1:0]);
  assign sat_in = in_tdata[HUE_W +: CB];
  assign bri_in = in_tdata[HUE_W+CB +: CB];

  always_comb begin
    s1_sec_nxt = SEC_RED;
    s1_rem_nxt = SW'(hue_ext);
    for (int j = 1; j < 6; j++) begin
      if (hue_ext >= CW'(j * SPAN)) begin
        s1_sec_nxt = sector_t'(j);
        s1_rem_nxt = SW'(hue_ext - CW'(j * SPAN));
      end
    end
    s1_oor_nxt = hue_ext >= CW'(6 * SPAN);
  end

  sector_t       s1_sec_r, s2_sec_r, s3_sec_r, s4_sec_r, s5_sec_r, s6_sec_r, s7_sec_r;
  logic          s1_oor_r, s2_oor_r, s3_oor_r, s4_oor_r, s5_oor_r, s6_oor_r, s7_oor_r;
  logic [CB-1:0] s1_bri_r, s2_bri_r, s3_bri_r, s4_bri_r, s5_bri_r, s6_bri_r, s7_bri_r;
  logic [SW-1:0] s1_rem_r;
  logic [CB-1:0] s1_sat_r;
  logic [CB-1:0] s2_a_r;
  logic [XW-1:0] s2_x_r;
  logic [XW-1:0] s2_y_r;
  logic [CB-1:0] s3_a_r;
  logic [XW-1:0] s3_nq_r;
  logic [XW-1:0] s3_nt_r;
  logic [ZW-1:0] s4_z_r [3];
  logic [ZW-1:0] s5_z_r [3];
  logic [EW-1:0] s5_est_r [3];
  logic [EW-1:0] s5_est_nxt [3];
  logic [WW-1:0] s6_w_r [3];
  logic [WW-1:0] s6_w_nxt [3];
  logic [CB-1:0] s7_p_r;
  logic [QW-1:0] s7_m_r [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_est_nxt[i] = EW'(((RMW'(s4_z_r[i]) + RMW'(s4_z_r[i] >> CB)) >> CB));
    end
  end

  always_comb begin
    logic [RMW-1:0] rem;
    for (int i = 0; i < 3; i++) begin
      rem = RMW'(s5_z_r[i]) - (RMW'(s5_est_r[i]) << CB) + RMW'(s5_est_r[i]);
      if (rem >= M2_C) begin
        s6_w_nxt[i] = WW'(s5_est_r[i]) + WW'(2);
      end else if (rem >= M1_C) begin
        s6_w_nxt[i] = WW'(s5_est_r[i]) + WW'(1);
      end else begin
        s6_w_nxt[i] = WW'(s5_est_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_sec_r <= s1_sec_nxt;
      s1_rem_r <= s1_rem_nxt;
      s1_oor_r <= s1_oor_nxt;
      s1_sat_r <= sat_in;
      s1_bri_r <= bri_in;
    end
    if (adv[1]) begin
      s2_a_r <= M_C - s1_sat_r;
      s2_x_r <= XW'(s1_sat_r) * XW'(s1_rem_r);
      s2_y_r <= XW'(s1_sat_r) * XW'(SPAN_C - s1_rem_r);
      s2_sec_r <= s1_sec_r;
      s2_oor_r <= s1_oor_r;
      s2_bri_r <= s1_bri_r;
    end
    if (adv[2]) begin
      s3_a_r <= s2_a_r;
      s3_nq_r <= MD_C - s2_x_r;
      s3_nt_r <= MD_C - s2_y_r;
      s3_sec_r <= s2_sec_r;
      s3_oor_r <= s2_oor_r;
      s3_bri_r <= s2_bri_r;
    end
    if (adv[3]) begin
      s4_z_r[0] <= ZW'(s3_bri_r) * ZW'(s3_a_r);
      s4_z_r[1] <= ZW'((PW'(s3_bri_r) * PW'(s3_nq_r)) >> (HUE_FRAC_BITS + 2));
      s4_z_r[2] <= ZW'((PW'(s3_bri_r) * PW'(s3_nt_r)) >> (HUE_FRAC_BITS + 2));
      s4_sec_r <= s3_sec_r;
      s4_oor_r <= s3_oor_r;
      s4_bri_r <= s3_bri_r;
    end
    if (adv[4]) begin
      s5_z_r <= s4_z_r;
      s5_est_r <= s5_est_nxt;
      s5_sec_r <= s4_sec_r;
      s5_oor_r <= s4_oor_r;
      s5_bri_r <= s4_bri_r;
    end
    if (adv[5]) begin
      s6_w_r <= s6_w_nxt;
      s6_sec_r <= s5_sec_r;
      s6_oor_r <= s5_oor_r;
      s6_bri_r <= s5_bri_r;
    end
    if (adv[6]) begin
      s7_p_r <= CB'(s6_w_r[0]);
      s7_m_r[0] <= QW'(s6_w_r[1]) * QW'(RECIP_C);
      s7_m_r[1] <= QW'(s6_w_r[2]) * QW'(RECIP_C);
      s7_sec_r <= s6_sec_r;
      s7_oor_r <= s6_oor_r;
      s7_bri_r <= s6_bri_r;
    end
  end

  // Channel routing.
  logic [CB-1:0] p_val, q_val, t_val;
  logic [CB-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CB-1:0] red_r, green_r, blue_r;
  logic          oor_r;

  assign p_val = s7_p_r;
  assign q_val = CB'(s7_m_r[0] >> K15);
  assign t_val = CB'(s7_m_r[1] >> K15);

  always_comb begin
    unique case (s7_sec_r)
      SEC_RED: begin
        red_nxt = s7_bri_r; green_nxt = t_val; blue_nxt = p_val;
      end
      SEC_YELLOW: begin
        red_nxt = q_val; green_nxt = s7_bri_r; blue_nxt = p_val;
      end
      SEC_GREEN: begin
        red_nxt = p_val; green_nxt = s7_bri_r; blue_nxt = t_val;
      end
      SEC_CYAN: begin
        red_nxt = p_val; green_nxt = q_val; blue_nxt = s7_bri_r;
      end
      SEC_BLUE: begin
        red_nxt = t_val; green_nxt = p_val; blue_nxt = s7_bri_r;
      end
      default: begin
        red_nxt = s7_bri_r; green_nxt = p_val; blue_nxt = q_val;
      end
    endcase
    if (s7_oor_r) begin
      red_nxt = '0;
      green_nxt = '0;
      blue_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      red_r <= red_nxt;
      green_r <= green_nxt;
      blue_r <= blue_nxt;
      oor_r <= s7_oor_r;
    end
  end

  assign out_tdata = OUT_W'({blue_r, green_r, red_r});
  assign out_tuser = oor_r;

endmodule
